FILE: sv/cc2p_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cc2p_pkg
// Shared widths, constants and the arctangent table for the CORDIC
// Cartesian-to-polar core.
// ----------------------------------------------------------------------------
package cc2p_pkg;

  // Number of micro-rotations (one pipeline stage each), at most TABLE_LEN
  localparam int ITERATIONS      = 16;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int TABLE_LEN       = 24;

  // Port field widths
  localparam int COORD_W = 16;
  localparam int MAG_W   = 17;
  localparam int ANGLE_W = 15;
  localparam int GAIN_W  = 16;

  // Internal widths: x/y grow by the CORDIC gain (about 1.65) and the pre-rotation
  localparam int XY_W   = COORD_W + 4;
  localparam int Z_W    = (ANGLE_FRAC_BITS + 4 > ANGLE_W + 1) ? ANGLE_FRAC_BITS + 4
                                                              : ANGLE_W + 1;
  localparam int PROD_W = XY_W - 1 + GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(39797);
  localparam logic [MAG_W-1:0]  MAG_MAX    = {MAG_W{1'b1}};

  localparam logic [35:0] HALF_PI_Q32 = 36'd6746518852;
  localparam logic [35:0] PI_Q32      = 36'd13493037705;

  // atan(2^-i) in unsigned Q0.32
  localparam logic [31:0] ATAN_Q32 [TABLE_LEN] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512
  };

  // Q0.32 angle to ANGLE_FRAC_BITS fraction bits, round to nearest, ties up
  function automatic logic [Z_W-1:0] ang_round(logic [35:0] q32);
    logic [35:0] r;
    r = (q32 + (36'd1 << (32 - ANGLE_FRAC_BITS - 1))) >> (32 - ANGLE_FRAC_BITS);
    return r[Z_W-1:0];
  endfunction

  localparam logic signed [Z_W-1:0] HALF_PI_Z = ang_round(HALF_PI_Q32);
  localparam logic signed [Z_W-1:0] PI_Z      = ang_round(PI_Q32);
  localparam logic signed [Z_W-1:0] NEG_PI_Z  = -PI_Z;
  localparam logic signed [Z_W-1:0] ANG_MAX_Z = Z_W'((1 << (ANGLE_W - 1)) - 1);
  localparam logic signed [Z_W-1:0] ANG_MIN_Z = -(ANG_MAX_Z + Z_W'(1));

endpackage
`default_nettype wire

FILE: sv/cc2p_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cc2p_in_if
// Valid/ready channel carrying one Cartesian point per beat.
// ----------------------------------------------------------------------------
interface cc2p_in_if;
  import cc2p_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface
`default_nettype wire

FILE: sv/cc2p_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cc2p_out_if
// Valid/ready channel carrying one magnitude/angle pair per beat.
// ----------------------------------------------------------------------------
interface cc2p_out_if;
  import cc2p_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [MAG_W-1:0]   magnitude;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output magnitude, output angle, input ready);
  modport sink   (input valid, input magnitude, input angle, output ready);
endinterface
`default_nettype wire

FILE: sv/cordic_cartesian_to_polar_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_cartesian_to_polar_core
// Pipelined vectoring-mode CORDIC: (x, y) in, magnitude and angle out.
// ----------------------------------------------------------------------------
// One point is accepted per clock while the pipe is not held by a stalled
// output. Each result passes through one stage for the +/-90 degree
// pre-rotation, one stage per shift-add micro-rotation, one for the
// gain-compensation multiply with the angle clamp, and the output
// register. The micro-rotation stages set the depth. A stalled output holds
// the whole pipe only once the stage in front of the output register is
// occupied, so one more beat is taken while a result waits. gain_comp is
// written through cfg_we_i/cfg_wdata_i and should change only while no
// beat is in flight.
// ----------------------------------------------------------------------------
module cordic_cartesian_to_polar_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [cc2p_pkg::GAIN_W-1:0] cfg_wdata_i,
  cc2p_in_if.sink                          in_i,
  cc2p_out_if.source                       out_o
);
  import cc2p_pkg::*;

  logic [GAIN_W-1:0] gain_comp_q;

  logic [ITERATIONS:0]     vld_q;
  logic signed [XY_W-1:0]  x_q [ITERATIONS+1];
  logic signed [XY_W-1:0]  y_q [ITERATIONS+1];
  logic signed [Z_W-1:0]   z_q [ITERATIONS+1];

  logic signed [XY_W-1:0]  x0_d, y0_d, xin, yin;
  logic signed [Z_W-1:0]   z0_d;

  logic                    mul_vld_q;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic signed [Z_W-1:0]   zc_q, zc_d, zfin;
  logic signed [XY_W-1:0]  xfin;

  logic                    out_vld_q;
  logic [MAG_W-1:0]        mag_q, mag_d;
  logic signed [ANGLE_W-1:0] ang_q;
  logic [PROD_W:0]         rnd;
  logic [PROD_W-16:0]      shifted;

  logic out_load, pipe_en;

  // Output register takes a beat when empty or drained this cycle
  assign out_load = !out_vld_q || out_o.ready;
  assign pipe_en  = !mul_vld_q || out_load;
  assign in_i.ready = pipe_en;

  assign out_o.valid     = out_vld_q;
  assign out_o.magnitude = mag_q;
  assign out_o.angle     = ang_q;

  // Gain compensation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_comp_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_comp_q <= cfg_wdata_i;
    end
  end

  // Pre-rotation by -90 (y > 0) or +90 degrees
  always_comb begin
    xin = XY_W'(in_i.x_coord);
    yin = XY_W'(in_i.y_coord);
    if (in_i.y_coord > 0) begin
      x0_d = yin;
      y0_d = -xin;
      z0_d = HALF_PI_Z;
    end else begin
      x0_d = -yin;
      y0_d = xin;
      z0_d = -HALF_PI_Z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[ITERATIONS-1:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      x_q[0] <= x0_d;
      y_q[0] <= y0_d;
      z_q[0] <= z0_d;
    end
  end

  // Micro-rotation stages, stage k+1 holds the result of rotation k
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
    localparam logic signed [Z_W-1:0] ATAN_Z = ang_round({4'd0, ATAN_Q32[k]});
    logic signed [XY_W-1:0] dx, dy, x_d, y_d;
    logic signed [Z_W-1:0]  z_d;

    always_comb begin
      dx = y_q[k] >>> k;
      dy = x_q[k] >>> k;
      if (!y_q[k][XY_W-1]) begin
        x_d = x_q[k] + dx;
        y_d = y_q[k] - dy;
        z_d = z_q[k] + ATAN_Z;
      end else begin
        x_d = x_q[k] - dx;
        y_d = y_q[k] + dy;
        z_d = z_q[k] - ATAN_Z;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        x_q[k+1] <= x_d;
        y_q[k+1] <= y_d;
        z_q[k+1] <= z_d;
      end
    end
  end

  // Gain multiply and angle clamp
  always_comb begin
    xfin = x_q[ITERATIONS];
    zfin = z_q[ITERATIONS];
    if (xfin[XY_W-1] || xfin == '0) begin
      prod_d = '0;
    end else begin
      prod_d = xfin[XY_W-2:0] * gain_comp_q;
    end
    priority if (zfin > PI_Z) begin
      zc_d = PI_Z;
    end else if (zfin < NEG_PI_Z) begin
      zc_d = NEG_PI_Z;
    end else begin
      zc_d = zfin;
    end
    priority if (zc_d > ANG_MAX_Z) begin
      zc_d = ANG_MAX_Z;
    end else if (zc_d < ANG_MIN_Z) begin
      zc_d = ANG_MIN_Z;
    end else begin
      zc_d = zc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (pipe_en) begin
      mul_vld_q <= vld_q[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      prod_q <= prod_d;
      zc_q   <= zc_d;
    end
  end

  // Round Q.16 product to nearest, ties up, then saturate
  always_comb begin
    rnd     = {1'b0, prod_q} + (PROD_W + 1)'(1 << 15);
    shifted = rnd[PROD_W:16];
    if (shifted > (PROD_W - 15)'(MAG_MAX)) begin
      mag_d = MAG_MAX;
    end else begin
      mag_d = shifted[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && mul_vld_q) begin
      mag_q <= mag_d;
      ang_q <= zc_q[ANGLE_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  // Input backpressure only when the multiply stage is full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (mul_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled without a full pipe");

  // An accepted beat lands in the pre-rotation stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted beat lost at pipe entry");

  // A held pipe keeps every valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> ($stable(vld_q) && $stable(mul_vld_q)))
    else $error("pipe valid bits moved during stall");

  // Delivered angle stays within [-pi, pi]
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (ang_q <= PI_Z && ang_q >= NEG_PI_Z))
    else $error("angle out of range");
`endif

endmodule
`default_nettype wire

FILE: bench/cordic_cartesian_to_polar_core_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_cartesian_to_polar_core_test
// Self-checking bench for the CORDIC Cartesian-to-polar core. Points go in
// on a valid/ready channel with random gaps and the result channel is
// stalled at random. Each accepted point is run through a local
// vectoring-mode predictor, and every result beat is checked against the
// oldest prediction. Covers axis and corner points, the origin, the
// negative x axis and several gain compensation settings.
// ----------------------------------------------------------------------------
module cordic_cartesian_to_polar_core_test;
  import cc2p_pkg::*;

  localparam int          PIPE_LATENCY = ITERATIONS + 3;
  localparam int          IDLE_PCT     = 23;
  localparam int          RANDOM_ITEMS = 2000;
  localparam int          STEADY_ITEMS = 300;
  localparam int          PRINT_LIMIT  = 30;
  localparam logic [15:0] DEFAULT_GAIN = 16'd39797;
  localparam logic [35:0] HALF_PI_FIX  = 36'd6746518852;
  localparam logic [35:0] PI_FIX       = 36'd13493037705;
  localparam int          MAG_LIMIT    = 131071;
  localparam int          ANG_HI       = 16383;
  localparam int          ANG_LO       = -16384;

  // atan(2^-i), unsigned Q0.32
  localparam logic [31:0] ARCTAN_FIX [24] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512
  };

  typedef struct packed {
    logic        [MAG_W-1:0]   magnitude;
    logic signed [ANGLE_W-1:0] angle;
  } polar_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [GAIN_W-1:0] cfg_wdata;
  logic [GAIN_W-1:0] gain_setting;
  bit               steady;
  int               mismatch_count;
  polar_t           polar_q[$];

  cc2p_in_if  pt_if ();
  cc2p_out_if res_if ();

  cordic_cartesian_to_polar_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (pt_if),
    .out_o      (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Q0.32 angle to the output fraction bits, round to nearest, ties up
  function automatic logic signed [31:0] fix_to_angle(input logic [35:0] q);
    logic [35:0] r;
    r = (q + (36'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);
    return $signed(r[31:0]);
  endfunction

  function automatic polar_t predict_polar(input logic signed [15:0] px,
                                           input logic signed [15:0] py);
    logic signed [31:0] xs, ys, xr, yr, zr, dx, dy, pi_a;
    logic [63:0]        prod;
    logic [63:0]        mag;
    polar_t             res;
    xs   = px;
    ys   = py;
    pi_a = fix_to_angle(PI_FIX);
    // pre-rotation: y == 0 takes the +90 degree branch
    if (ys > 0) begin
      xr = ys;
      yr = -xs;
      zr = fix_to_angle(HALF_PI_FIX);
    end else begin
      xr = -ys;
      yr = xs;
      zr = -fix_to_angle(HALF_PI_FIX);
    end
    for (int i = 0; i < ITERATIONS && i < 24; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (yr >= 0) begin
        xr = xr + dx;
        yr = yr - dy;
        zr = zr + fix_to_angle({4'd0, ARCTAN_FIX[i]});
      end else begin
        xr = xr - dx;
        yr = yr + dy;
        zr = zr - fix_to_angle({4'd0, ARCTAN_FIX[i]});
      end
    end
    if (xr <= 0) begin
      mag = '0;
    end else begin
      prod = 64'(xr) * 64'(gain_setting);
      mag  = (prod + 64'd32768) >> 16;
      if (mag > 64'(MAG_LIMIT)) mag = 64'(MAG_LIMIT);
    end
    if (zr > pi_a) zr = pi_a;
    if (zr < -pi_a) zr = -pi_a;
    if (zr > ANG_HI) zr = ANG_HI;
    if (zr < ANG_LO) zr = ANG_LO;
    res.magnitude = mag[MAG_W-1:0];
    res.angle     = zr[ANGLE_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      pt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pt_if.valid   <= 1'b1;
    pt_if.x_coord <= x;
    pt_if.y_coord <= y;
    do @(posedge clk_i); while (!pt_if.ready);
    polar_q.push_back(predict_polar(x, y));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    pt_if.valid <= 1'b0;
    while (polar_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  // only called with the pipe empty
  task automatic set_gain(input logic [GAIN_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we       <= 1'b0;
    gain_setting = value;
  endtask

  function automatic logic signed [15:0] pick_coord();
    logic signed [15:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = 16'($urandom);
      5:             v = 16'($signed($urandom_range(127)) - 64);
      6: begin
        case ($urandom_range(4))
          0:       v = 16'sh8000;
          1:       v = 16'sh7fff;
          2:       v = -16'sd1;
          3:       v = 16'sd1;
          default: v = 16'sd0;
        endcase
      end
      default:       v = 16'($urandom_range(32767));
    endcase
    return v;
  endfunction

  task automatic send_random_point();
    logic signed [15:0] x, y;
    x = pick_coord();
    y = pick_coord();
    case ($urandom_range(9))
      0: y = 16'sd0;                                   // x axis
      1: x = 16'sd0;                                   // y axis
      2: begin                                         // near negative x axis
        x = -16'($urandom_range(32768, 1));
        y = 16'($signed($urandom_range(8)) - 4);
      end
      3: y = x;                                        // diagonal
      default: ;
    endcase
    send_point(x, y);
  endtask

  task automatic test_directed_points();
    send_point(16'sd0, 16'sd0);
    send_point(16'sh7fff, 16'sd0);
    send_point(16'sh8000, 16'sd0);
    send_point(16'sd0, 16'sh7fff);
    send_point(16'sd0, 16'sh8000);
    send_point(16'sh7fff, 16'sh7fff);
    send_point(16'sh8000, 16'sh8000);
    send_point(16'sh7fff, 16'sh8000);
    send_point(16'sh8000, 16'sh7fff);
    send_point(16'sd1, 16'sd0);
    send_point(-16'sd1, 16'sd0);
    send_point(16'sd0, 16'sd1);
    send_point(16'sd0, -16'sd1);
    send_point(-16'sd1, -16'sd1);
    send_point(-16'sd1, 16'sd1);
    send_point(-16'sd16384, 16'sd0);
    send_point(-16'sd16384, 16'sd1);
    send_point(-16'sd16384, -16'sd1);
    send_point(16'sd16384, 16'sd16384);
    send_point(16'sh5555, 16'shaaaa);
    send_point(16'shaaaa, 16'sh5555);
    wait_drained();
  endtask

  task automatic test_gain_settings();
    logic [GAIN_W-1:0] gains [5];
    gains = '{16'd0, 16'hffff, 16'd1, 16'h8000, 16'($urandom)};
    foreach (gains[g]) begin
      set_gain(gains[g]);
      send_point(16'sh7fff, 16'sh7fff);
      send_point(16'sh8000, 16'sh8000);
      repeat (40) send_random_point();
      wait_drained();
    end
    set_gain(DEFAULT_GAIN);
  endtask

  task automatic test_random_points();
    steady = 1'b1;
    repeat (STEADY_ITEMS) send_random_point();
    steady = 1'b0;
    repeat (RANDOM_ITEMS - STEADY_ITEMS) send_random_point();
    wait_drained();
  endtask

  always @(negedge clk_i)
    res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin : check_result
      polar_t want;
      if (polar_q.size() == 0) begin
        report_mismatch("unexpected beat, magnitude", int'(res_if.magnitude), -1);
      end else begin
        want = polar_q.pop_front();
        if (res_if.magnitude !== want.magnitude)
          report_mismatch("magnitude", int'(res_if.magnitude), int'(want.magnitude));
        if (res_if.angle !== want.angle)
          report_mismatch("angle", int'(res_if.angle), int'(want.angle));
      end
    end
  end

  initial begin
    #(200000 * 12);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    gain_setting   = DEFAULT_GAIN;
    steady         = 1'b0;
    mismatch_count = 0;
    pt_if.valid    = 1'b0;
    pt_if.x_coord  = '0;
    pt_if.y_coord  = '0;
    res_if.ready   = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_points();
    test_gain_settings();
    test_random_points();

    if (mismatch_count == 0 && polar_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
